[hw/rtl/keyword_score_argmax_confirm_defines.svh]
// Assertion macros shared by the keyword score argmax checker.
`ifndef KEYWORD_SCORE_ARGMAX_CONFIRM_DEFINES_SVH
`define KEYWORD_SCORE_ARGMAX_CONFIRM_DEFINES_SVH

// Same-cycle implication, checked on the rising edge, off while reset is low.
`define KSAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge, off while reset is low.
`define KSAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/kwsac_pkg.sv]
// Types and constants of the keyword score argmax confirmation block.
package kwsac_pkg;

    localparam int CATEGORIES_DEF = 4;

    localparam int SCORE_W   = 8;
    localparam int DIFF_W    = 9;
    localparam int CODE_W    = 8;
    localparam int CAT_W     = 6;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [SCORE_W-1:0]   ZERO_POINT_RST = 8'd0;
    localparam logic [CODE_W-1:0]    RECORD_THR_RST = 8'd204;
    localparam logic [CODE_W-1:0]    DIRECT_THR_RST = 8'd243;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd1000;

    typedef enum logic [1:0] {
        OUT_BELOW   = 2'd0,
        OUT_DIRECT  = 2'd1,
        OUT_CONFIRM = 2'd2,
        OUT_RECORD  = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_POINT = 2'd0,
        CFG_RECORD_THR = 2'd1,
        CFG_DIRECT_THR = 2'd2,
        CFG_TIMEOUT    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [CODE_W-1:0]    record_thr;
        logic [CODE_W-1:0]    direct_thr;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } t_thresholds;

    typedef struct packed {
        t_outcome outcome;
        logic     fired;
    } t_decision;

endpackage

[hw/rtl/keyword_score_argmax_confirm.sv]
// Top level: running argmax over class scores with threshold and confirmation.
// A last score passes the input register, then its decision fills the result register.
// Throughput: one class score per cycle; a result stalled at the output holds
// the pipeline only when the next last score reaches the decision stage.
// Reset (i_rst_n low at a clock edge) empties both stages, clears the argmax and
// pending detection, and loads the register defaults 0, 204, 243 and 1000.
module keyword_score_argmax_confirm #(
    parameter int CATEGORIES = kwsac_pkg::CATEGORIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // score channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [kwsac_pkg::SCORE_W-1:0] i_score,
    input  logic                                i_last,
    input  logic [kwsac_pkg::TIME_W-1:0]        i_time_ms,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_outcome,
    output logic                                o_fired,
    output logic [kwsac_pkg::CAT_W-1:0]         o_category,
    output logic [kwsac_pkg::CODE_W-1:0]        o_score_code,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kwsac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kwsac_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int POS_W = $clog2(CATEGORIES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CATEGORIES - 1);

    // ---------------------------------------------------------------
    // Configuration registers; the user must write them only while the block is
    // idle. The block does not enforce this, and the port accepts every transfer.
    // ---------------------------------------------------------------
    logic [kwsac_pkg::SCORE_W-1:0] r_zero_point;
    kwsac_pkg::t_thresholds        r_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_point     <= kwsac_pkg::ZERO_POINT_RST;
            r_thr.record_thr <= kwsac_pkg::RECORD_THR_RST;
            r_thr.direct_thr <= kwsac_pkg::DIRECT_THR_RST;
            r_thr.timeout_ms <= kwsac_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (kwsac_pkg::t_cfg_index'(i_cfg_index))
                kwsac_pkg::CFG_ZERO_POINT: r_zero_point     <= i_cfg_data[7:0];
                kwsac_pkg::CFG_RECORD_THR: r_thr.record_thr <= i_cfg_data[7:0];
                kwsac_pkg::CFG_DIRECT_THR: r_thr.direct_thr <= i_cfg_data[7:0];
                kwsac_pkg::CFG_TIMEOUT:    r_thr.timeout_ms <= i_cfg_data;
                default:                   r_zero_point     <= r_zero_point;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: input register. Advance into stage 2 unless a last score
    // sits here and the result register is still full.
    // ---------------------------------------------------------------
    logic                           r_s1_valid;
    logic [kwsac_pkg::SCORE_W-1:0]  r_s1_score;
    logic                           r_s1_last;
    logic [kwsac_pkg::TIME_W-1:0]   r_s1_time;
    logic                           out_free;
    logic                           s1_adv;
    logic                           s1_eval;

    assign out_free   = !o_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && (!r_s1_last || out_free);
    assign s1_eval    = s1_adv && r_s1_last;
    assign o_in_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Payload: load on every input transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_score <= i_score;
            r_s1_last  <= i_last;
            r_s1_time  <= i_time_ms;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: running argmax. The best value starts at zero, so only a
    // strictly positive difference wins; ties keep the earlier class.
    // ---------------------------------------------------------------
    logic [POS_W-1:0]               r_pos;
    logic [kwsac_pkg::CODE_W-1:0]   r_best_diff;
    logic [POS_W-1:0]               r_best_idx;
    logic signed [kwsac_pkg::DIFF_W-1:0] diff;
    logic                           take_new;
    logic [kwsac_pkg::CODE_W-1:0]   cur_diff;
    logic [POS_W-1:0]               cur_idx;
    logic [kwsac_pkg::CAT_W-1:0]    cur_cat;

    assign diff = $signed({r_s1_score[kwsac_pkg::SCORE_W-1], r_s1_score})
                - $signed({r_zero_point[kwsac_pkg::SCORE_W-1], r_zero_point});
    assign take_new = diff > $signed({1'b0, r_best_diff});
    assign cur_diff = take_new ? diff[kwsac_pkg::CODE_W-1:0] : r_best_diff;
    assign cur_idx  = take_new ? r_pos : r_best_idx;
    assign cur_cat  = kwsac_pkg::CAT_W'(cur_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_best_diff <= '0;
            r_best_idx  <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                // Start the next inference from scratch.
                r_pos       <= '0;
                r_best_diff <= '0;
                r_best_idx  <= '0;
            end else begin
                // Wrap the class position past the last category.
                r_pos       <= (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
                r_best_diff <= cur_diff;
                r_best_idx  <= cur_idx;
            end
        end
    end

    // Threshold compare and pending-detection bookkeeping on the last score.
    kwsac_pkg::t_decision decision;

    kwsac_pending u_pending (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_eval     (s1_eval),
        .i_code     (cur_diff),
        .i_cat      (cur_cat),
        .i_now      (r_s1_time),
        .i_thr      (r_thr),
        .o_decision (decision)
    );

    // ---------------------------------------------------------------
    // Result register: fill on the last score, drop on an output transfer.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_eval) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_eval) begin
            o_outcome    <= decision.outcome;
            o_fired      <= decision.fired;
            o_category   <= cur_cat;
            o_score_code <= cur_diff;
        end
    end

endmodule

[hw/rtl/kwsac_pending.sv]
// Threshold decision and pending-detection state of the keyword block.
module kwsac_pending (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_eval,
    input  logic [kwsac_pkg::CODE_W-1:0]     i_code,
    input  logic [kwsac_pkg::CAT_W-1:0]      i_cat,
    input  logic [kwsac_pkg::TIME_W-1:0]     i_now,
    input  kwsac_pkg::t_thresholds           i_thr,
    output kwsac_pkg::t_decision             o_decision
);

    logic                          r_pend_valid;
    logic [kwsac_pkg::CAT_W-1:0]   r_pend_cat;
    logic [kwsac_pkg::TIME_W-1:0]  r_pend_time;
    logic                          n_pend_valid;
    logic [kwsac_pkg::CAT_W-1:0]   n_pend_cat;
    logic [kwsac_pkg::TIME_W-1:0]  n_pend_time;

    logic [kwsac_pkg::TIME_W-1:0]  elapsed;
    logic                          in_window;
    logic                          same_cat;

    // Elapsed time wraps modulo 2^32.
    assign elapsed   = i_now - r_pend_time;
    assign in_window = elapsed < kwsac_pkg::TIME_W'(i_thr.timeout_ms);
    assign same_cat  = r_pend_valid && (r_pend_cat == i_cat);

    always_comb begin
        o_decision.outcome = kwsac_pkg::OUT_BELOW;
        o_decision.fired   = 1'b0;
        n_pend_valid       = 1'b0;
        n_pend_cat         = '0;
        n_pend_time        = '0;
        priority if (i_code <= i_thr.record_thr) begin
            o_decision.outcome = kwsac_pkg::OUT_BELOW;
        end else if (i_code > i_thr.direct_thr) begin
            o_decision.outcome = kwsac_pkg::OUT_DIRECT;
            o_decision.fired   = 1'b1;
        end else if (same_cat && in_window) begin
            o_decision.outcome = kwsac_pkg::OUT_CONFIRM;
            o_decision.fired   = 1'b1;
        end else begin
            // Record a new pending detection.
            o_decision.outcome = kwsac_pkg::OUT_RECORD;
            n_pend_valid       = 1'b1;
            n_pend_cat         = i_cat;
            n_pend_time        = i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_cat   <= '0;
            r_pend_time  <= '0;
        end else if (i_eval) begin
            r_pend_valid <= n_pend_valid;
            r_pend_cat   <= n_pend_cat;
            r_pend_time  <= n_pend_time;
        end
    end

endmodule

[hw/rtl/kwsac_checker.sv]
// Port-level checker for the keyword block, bound to the top level.
`include "keyword_score_argmax_confirm_defines.svh"

module kwsac_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [1:0]                      o_outcome,
    input logic                            o_fired,
    input logic [kwsac_pkg::CAT_W-1:0]     o_category,
    input logic [kwsac_pkg::CODE_W-1:0]    o_score_code
);

    // Fired marks exactly the direct and confirmed outcomes.
    `KSAC_ASSERT_NOW(a_fired_match, i_clk, i_rst_n, o_out_valid, o_fired == ((o_outcome == kwsac_pkg::OUT_DIRECT) || (o_outcome == kwsac_pkg::OUT_CONFIRM)), "fired disagrees with outcome")

    // Any detection needs a positive winning score.
    `KSAC_ASSERT_NOW(a_detect_code, i_clk, i_rst_n, o_out_valid && (o_outcome != kwsac_pkg::OUT_BELOW), o_score_code != '0, "detection with zero score")

    // No positive score means class zero won.
    `KSAC_ASSERT_NOW(a_zero_cat, i_clk, i_rst_n, o_out_valid && (o_score_code == '0), o_category == '0, "nonzero category without a positive score")

    // A stalled result holds.
    `KSAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_outcome) && $stable(o_category) && $stable(o_score_code), "stalled result changed")

endmodule

bind keyword_score_argmax_confirm kwsac_checker u_kwsac_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_outcome    (o_outcome),
    .o_fired      (o_fired),
    .o_category   (o_category),
    .o_score_code (o_score_code)
);

[tb/tb_keyword_score_argmax_confirm.sv]
// Self-checking testbench for the keyword score argmax and confirmation block.
module tb_keyword_score_argmax_confirm;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CLASSES = kwsac_pkg::CATEGORIES_DEF;
    // A result is registered after its last score leaves the input register; pad a little.
    localparam int RESULT_LAG  = 4;

    // One decision as it leaves the block.
    typedef struct packed {
        kwsac_pkg::t_outcome          outcome;
        logic                         fired;
        logic [kwsac_pkg::CAT_W-1:0]  category;
        logic [kwsac_pkg::CODE_W-1:0] code;
    } t_check;

    // One row of the directed table: either a register write or a score transfer.
    typedef struct {
        bit                                   is_reg;
        kwsac_pkg::t_cfg_index                reg_idx;
        logic [kwsac_pkg::CFG_DAT_W-1:0]      reg_val;
        logic signed [kwsac_pkg::SCORE_W-1:0] score;
        logic                                 last;
        logic [kwsac_pkg::TIME_W-1:0]         stamp;
        bit                                   typed;
        t_check                               want;
    } t_plan_row;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_in_valid  = 1'b0;
    logic                                 o_in_ready;
    logic signed [kwsac_pkg::SCORE_W-1:0] i_score     = '0;
    logic                                 i_last      = 1'b0;
    logic [kwsac_pkg::TIME_W-1:0]         i_time_ms   = '0;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic [1:0]                           o_outcome;
    logic                                 o_fired;
    logic [kwsac_pkg::CAT_W-1:0]          o_category;
    logic [kwsac_pkg::CODE_W-1:0]         o_score_code;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    kwsac_pkg::t_cfg_index                i_cfg_index = kwsac_pkg::CFG_ZERO_POINT;
    logic [kwsac_pkg::CFG_DAT_W-1:0]      i_cfg_data  = '0;

    // Typed-in expectation that travels with the score currently offered.
    bit     tag_typed = 1'b0;
    t_check tag_want  = '0;

    // Predictor copy of the registers and the block state.
    logic signed [kwsac_pkg::SCORE_W-1:0] m_zero_point;
    logic [kwsac_pkg::CODE_W-1:0]         m_record_thr;
    logic [kwsac_pkg::CODE_W-1:0]         m_direct_thr;
    logic [kwsac_pkg::TIMEOUT_W-1:0]      m_timeout;
    logic [kwsac_pkg::CAT_W-1:0]          m_position;
    logic [kwsac_pkg::CODE_W-1:0]         m_best_diff;
    logic [kwsac_pkg::CAT_W-1:0]          m_best_index;
    logic                                 m_pend_valid;
    logic [kwsac_pkg::CAT_W-1:0]          m_pend_cat;
    logic [kwsac_pkg::TIME_W-1:0]         m_pend_time;

    t_check                       awaited_decisions[$];
    int                           scores_taken   = 0;
    int                           results_seen   = 0;
    int                           mismatch_count = 0;
    int                           last_winner    = 0;
    logic [kwsac_pkg::TIME_W-1:0] ms_clock       = '0;

    // Receiver hold-off bookkeeping, owned by the ready process.
    int hold_left = 0;
    bit hold_done = 1'b0;

    keyword_score_argmax_confirm dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_score      (i_score),
        .i_last       (i_last),
        .i_time_ms    (i_time_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_outcome    (o_outcome),
        .o_fired      (o_fired),
        .o_category   (o_category),
        .o_score_code (o_score_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Count a failure; print only the first ten.
    function automatic void flag_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s", $time, what);
        end
    endfunction

    // No idling on either side while this window of transfers is in progress.
    function automatic bit quiet_window();
        return scores_taken >= 450 && scores_taken < 600;
    endfunction

    // Advance the argmax by one score; on the last score, decide and return 1.
    function automatic bit argmax_decide(input logic signed [kwsac_pkg::SCORE_W-1:0] raw,
                                         input logic is_last,
                                         input logic [kwsac_pkg::TIME_W-1:0] now,
                                         output t_check res);
        int                           diff;
        logic [kwsac_pkg::TIME_W-1:0] elapsed;
        res  = '0;
        diff = int'(raw) - int'(m_zero_point);
        // Strictly greater: a tie keeps the earlier class, and the argmax starts at zero.
        if (diff > int'(m_best_diff)) begin
            m_best_diff  = diff[kwsac_pkg::CODE_W-1:0];
            m_best_index = m_position;
        end
        if (!is_last) begin
            // Wrap the class position when an inference runs past the class count.
            m_position = (int'(m_position) + 1 >= NUM_CLASSES) ? '0 : m_position + 1'b1;
            return 1'b0;
        end
        res.category = m_best_index;
        res.code     = m_best_diff;
        elapsed      = now - m_pend_time;
        if (m_best_diff <= m_record_thr) begin
            res.outcome = kwsac_pkg::OUT_BELOW;
            {m_pend_valid, m_pend_cat, m_pend_time} = '0;
        end else if (m_best_diff > m_direct_thr) begin
            res.outcome = kwsac_pkg::OUT_DIRECT;
            res.fired   = 1'b1;
            {m_pend_valid, m_pend_cat, m_pend_time} = '0;
        end else if (m_pend_valid && m_pend_cat == m_best_index &&
                     elapsed < kwsac_pkg::TIME_W'(m_timeout)) begin
            res.outcome = kwsac_pkg::OUT_CONFIRM;
            res.fired   = 1'b1;
            {m_pend_valid, m_pend_cat, m_pend_time} = '0;
        end else begin
            res.outcome  = kwsac_pkg::OUT_RECORD;
            m_pend_valid = 1'b1;
            m_pend_cat   = m_best_index;
            m_pend_time  = now;
        end
        m_position   = '0;
        m_best_diff  = '0;
        m_best_index = '0;
        return 1'b1;
    endfunction

    // Watch all three channels at the clock edge: check results, predict, track registers.
    always @(posedge i_clk) begin : channel_monitor
        t_check seen;
        t_check want;
        t_check predicted;
        if (!i_rst_n) begin
            m_zero_point = kwsac_pkg::ZERO_POINT_RST;
            m_record_thr = kwsac_pkg::RECORD_THR_RST;
            m_direct_thr = kwsac_pkg::DIRECT_THR_RST;
            m_timeout    = kwsac_pkg::TIMEOUT_RST;
            m_position   = '0;
            m_best_diff  = '0;
            m_best_index = '0;
            {m_pend_valid, m_pend_cat, m_pend_time} = '0;
        end else begin
            // Compare a result transfer with the oldest expectation.
            if (o_out_valid && i_out_ready) begin
                seen.outcome  = kwsac_pkg::t_outcome'(o_outcome);
                seen.fired    = o_fired;
                seen.category = o_category;
                seen.code     = o_score_code;
                if (awaited_decisions.size() == 0) begin
                    flag_failure($sformatf("result %0d arrived with nothing expected",
                                           results_seen));
                end else begin
                    want = awaited_decisions.pop_front();
                    if (seen.outcome !== want.outcome || seen.fired !== want.fired ||
                        seen.category !== want.category || seen.code !== want.code) begin
                        flag_failure($sformatf({"result %0d mismatch: expected outcome %0d ",
                            "fired %0d category %0d code %0d, got outcome %0d fired %0d ",
                            "category %0d code %0d"}, results_seen, want.outcome, want.fired,
                            want.category, want.code, seen.outcome, seen.fired, seen.category,
                            seen.code));
                    end
                end
                results_seen++;
            end
            // Predict on every score transfer; a typed-in row overrides the prediction.
            if (i_in_valid && o_in_ready) begin
                scores_taken++;
                if (argmax_decide(i_score, i_last, i_time_ms, predicted)) begin
                    awaited_decisions.push_back(tag_typed ? tag_want : predicted);
                end
            end
            // Track register writes; narrow registers keep only their low bits.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    kwsac_pkg::CFG_ZERO_POINT:
                        m_zero_point = i_cfg_data[kwsac_pkg::SCORE_W-1:0];
                    kwsac_pkg::CFG_RECORD_THR:
                        m_record_thr = i_cfg_data[kwsac_pkg::CODE_W-1:0];
                    kwsac_pkg::CFG_DIRECT_THR:
                        m_direct_thr = i_cfg_data[kwsac_pkg::CODE_W-1:0];
                    kwsac_pkg::CFG_TIMEOUT:
                        m_timeout    = i_cfg_data[kwsac_pkg::TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result side: random stalls, one long hold-off to back the block up, a quiet window.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && scores_taken >= 300) begin
            // Hold off the result channel while the sender keeps offering scores.
            i_out_ready <= 1'b0;
            hold_left   <= 150;
            hold_done   <= 1'b1;
        end else if (quiet_window()) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 37);
        end
    end

    function automatic t_plan_row row_score(input logic signed [kwsac_pkg::SCORE_W-1:0] s,
                                            input logic l,
                                            input logic [kwsac_pkg::TIME_W-1:0] t);
        t_plan_row r;
        r = '{is_reg: 1'b0, reg_idx: kwsac_pkg::CFG_ZERO_POINT, reg_val: '0, score: '0,
              last: 1'b0, stamp: '0, typed: 1'b0, want: '0};
        r.score = s;
        r.last  = l;
        r.stamp = t;
        return r;
    endfunction

    function automatic t_plan_row row_reg(input kwsac_pkg::t_cfg_index idx,
                                          input logic [kwsac_pkg::CFG_DAT_W-1:0] val);
        t_plan_row r;
        r         = row_score('0, 1'b0, '0);
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Last score of an inference with its decision typed in.
    function automatic t_plan_row row_check(input logic signed [kwsac_pkg::SCORE_W-1:0] s,
                                            input logic [kwsac_pkg::TIME_W-1:0] t,
                                            input kwsac_pkg::t_outcome oc,
                                            input logic f,
                                            input logic [kwsac_pkg::CAT_W-1:0] cat,
                                            input logic [kwsac_pkg::CODE_W-1:0] code);
        t_plan_row r;
        r               = row_score(s, 1'b1, t);
        r.typed         = 1'b1;
        r.want.outcome  = oc;
        r.want.fired    = f;
        r.want.category = cat;
        r.want.code     = code;
        return r;
    endfunction

    // Offer one score, idling at random first, and hold it until it transfers.
    task automatic send_score(input logic signed [kwsac_pkg::SCORE_W-1:0] s, input logic l,
                              input logic [kwsac_pkg::TIME_W-1:0] t, input bit typed,
                              input t_check want);
        while (!quiet_window() && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_score    <= s;
        i_last     <= l;
        i_time_ms  <= t;
        tag_typed  <= typed;
        tag_want   <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Write one register, then drop valid again.
    task automatic write_reg(input kwsac_pkg::t_cfg_index idx,
                             input logic [kwsac_pkg::CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering scores and wait until every decision is out and the pipe is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_decisions.size() != 0) @(posedge i_clk);
        repeat (RESULT_LAG) @(posedge i_clk);
    endtask

    // Send one inference. Most are full-length with a winner in a band set by the thresholds or in the
    // full range, and often the previous winner again; the rest are random noise of random length.
    task automatic send_inference(output int count);
        int                                   len;
        int                                   winner;
        int                                   lo;
        int                                   hi;
        int                                   raw;
        bit                                   shaped;
        logic signed [kwsac_pkg::SCORE_W-1:0] s;
        t_check                               blank;
        blank  = '0;
        shaped = ($urandom_range(99) < 75);
        len    = shaped ? NUM_CLASSES : 1 + int'($urandom_range(2 * NUM_CLASSES - 1));
        winner = ($urandom_range(99) < 60) ? last_winner : int'($urandom_range(NUM_CLASSES - 1));
        case ($urandom_range(3))
            0: begin
                lo = int'(m_record_thr) + 1;
                hi = int'(m_direct_thr);
            end
            1: begin
                lo = int'(m_direct_thr) + 1;
                hi = 255;
            end
            2: begin
                lo = 0;
                hi = int'(m_record_thr);
            end
            default: begin
                lo = 0;
                hi = 255;
            end
        endcase
        if (lo > hi) begin
            lo = 0;
            hi = 255;
        end
        raw = lo + int'($urandom_range(hi - lo)) + int'(m_zero_point);
        if (raw > 127) raw = 127;
        if (raw < -128) raw = -128;
        // Step the clock mostly within reach of the timeout, now and then jump anywhere.
        if ($urandom_range(19) == 0) begin
            ms_clock = $urandom;
        end else begin
            ms_clock = ms_clock + kwsac_pkg::TIME_W'(
                $urandom_range((m_timeout == 0) ? 50 : 2 * int'(m_timeout)));
        end
        for (int i = 0; i < len; i++) begin
            if (shaped && i == winner) begin
                s = 8'(raw);
            end else if (shaped && $urandom_range(1) == 1) begin
                s = 8'h80;  // lowest score, leave the winner alone
            end else begin
                s = 8'($urandom);
            end
            send_score(s, (i == len - 1),
                       (i == len - 1) ? ms_clock : kwsac_pkg::TIME_W'($urandom),
                       1'b0, blank);
        end
        if (shaped) last_winner = winner;
        count = len;
    endtask

    initial begin : stimulus
        t_plan_row        plan[$];
        int               taken;
        int               n;
        logic [7:0]       zp;
        logic [7:0]       rec;
        logic [7:0]       dir;
        logic [15:0]      tmo;

        // Defaults, zero point 0: no difference exceeds 127, so nothing is detected.
        plan.push_back(row_score(8'sh7F, 1'b0, '0));
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_check(8'sd0, 32'hFFFF_FFFF, kwsac_pkg::OUT_BELOW, 1'b0, 6'd0,
                                 8'd127));
        // No positive difference: category and code stay zero.
        plan.push_back(row_score(-8'sd1, 1'b0, '0));
        plan.push_back(row_check(8'sh80, 32'd0, kwsac_pkg::OUT_BELOW, 1'b0, 6'd0, 8'd0));
        // Zero point -128 lifts every score into the full unsigned range.
        plan.push_back(row_reg(kwsac_pkg::CFG_ZERO_POINT, 16'hFF80));
        plan.push_back(row_check(8'sh7F, 32'd50, kwsac_pkg::OUT_DIRECT, 1'b1, 6'd0, 8'd255));
        // Tie between classes 1 and 2 keeps class 1; between the thresholds it records.
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sd100, 1'b0, '0));
        plan.push_back(row_check(8'sd100, 32'd1000, kwsac_pkg::OUT_RECORD, 1'b0, 6'd1,
                                 8'd228));
        // Same class 999 ms later confirms.
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_check(8'sd90, 32'd1999, kwsac_pkg::OUT_CONFIRM, 1'b1, 6'd1,
                                 8'd218));
        // Record just before the timestamp wraps, confirm just after it.
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sd80, 1'b1, 32'hFFFF_FFF0));
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sd99, 1'b1, 32'h0000_0100));
        // Six scores in one inference: the position wraps and later scores still compete.
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sh80, 1'b0, '0));
        plan.push_back(row_score(8'sd95, 1'b0, '0));
        plan.push_back(row_score(8'sd96, 1'b1, 32'd5000));
        // Below the record threshold clears the pending detection.
        plan.push_back(row_score(8'sd0, 1'b1, 32'd5001));
        // Direct threshold under the record threshold: anything recorded fires directly.
        plan.push_back(row_reg(kwsac_pkg::CFG_RECORD_THR, 16'h0064));
        plan.push_back(row_reg(kwsac_pkg::CFG_DIRECT_THR, 16'h0032));
        plan.push_back(row_check(8'sd22, 32'd7, kwsac_pkg::OUT_DIRECT, 1'b1, 6'd0, 8'd150));
        // Zero timeout: a repeat at the same instant records again instead of confirming.
        plan.push_back(row_reg(kwsac_pkg::CFG_DIRECT_THR, 16'h00FF));
        plan.push_back(row_reg(kwsac_pkg::CFG_TIMEOUT, 16'h0000));
        plan.push_back(row_score(8'sd22, 1'b1, 32'd10));
        plan.push_back(row_score(8'sd22, 1'b1, 32'd10));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; register rows wait for the block to go idle.
        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_score(plan[k].score, plan[k].last, plan[k].stamp, plan[k].typed,
                           plan[k].want);
            end
        end

        // Random phases, each under its own register setting, extremes first.
        ms_clock = $urandom;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    zp = 8'h80; rec = 8'd204; dir = 8'd243; tmo = 16'd1000;
                end
                1: begin
                    zp = 8'h7F; rec = 8'd0; dir = 8'd0; tmo = 16'hFFFF;
                end
                2: begin
                    zp = 8'h80; rec = 8'd255; dir = 8'd255; tmo = 16'd0;
                end
                3: begin
                    zp = 8'h80; rec = 8'd0; dir = 8'd255; tmo = 16'hFFFF;
                end
                default: begin
                    zp  = ($urandom_range(1) == 1) ? 8'($urandom_range(8'hC0, 8'h80))
                                                   : 8'($urandom);
                    rec = 8'($urandom);
                    dir = 8'($urandom);
                    tmo = ($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(2000, 1));
                end
            endcase
            settle();
            write_reg(kwsac_pkg::CFG_ZERO_POINT, {8'($urandom), zp});
            write_reg(kwsac_pkg::CFG_RECORD_THR, {8'($urandom), rec});
            write_reg(kwsac_pkg::CFG_DIRECT_THR, {8'($urandom), dir});
            write_reg(kwsac_pkg::CFG_TIMEOUT, tmo);
            taken = 0;
            while (taken < 100) begin
                send_inference(n);
                taken += n;
            end
        end

        // Drain, give the pipe time to show any stray result, then report.
        settle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_decisions.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
